// ===== design/argb_color_matrix_pixel_top_assert.svh =====
// Assertion macros for the colour matrix top level.
`ifndef ARGB_COLOR_MATRIX_PIXEL_TOP_ASSERT_SVH
`define ARGB_COLOR_MATRIX_PIXEL_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, held off during reset.
`define ACM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("colour matrix assertion failed");
// Next-cycle implication, held off during reset.
`define ACM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("colour matrix assertion failed");
`else
`define ACM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ACM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/acm_pkg.sv =====
// Types, register indexes and helpers for the ARGB colour matrix block.
package acm_pkg;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int COEF_W    = 16;
  // 9-bit signed operand times 16-bit coefficient, five terms summed.
  localparam int ACC_W     = 28;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // Register indexes on the configuration port.
  localparam cfg_idx_t REG_RED_WEIGHTS   = 3'd0;
  localparam cfg_idx_t REG_GREEN_WEIGHTS = 3'd1;
  localparam cfg_idx_t REG_BLUE_WEIGHTS  = 3'd2;
  localparam cfg_idx_t REG_ALPHA_WEIGHTS = 3'd3;
  localparam cfg_idx_t REG_OFFSET_TERMS  = 3'd4;

  // Reset values give the identity matrix.
  localparam logic [CFG_W-1:0] RST_RED_WEIGHTS   = 64'h0000_0000_0000_1000;
  localparam logic [CFG_W-1:0] RST_GREEN_WEIGHTS = 64'h0000_0000_1000_0000;
  localparam logic [CFG_W-1:0] RST_BLUE_WEIGHTS  = 64'h0000_1000_0000_0000;
  localparam logic [CFG_W-1:0] RST_ALPHA_WEIGHTS = 64'h1000_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_OFFSET_TERMS  = 64'h0000_0000_0000_0000;

  // Request type codes.
  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_RGB   = 2'd1;
  localparam logic [1:0] MODE_ALPHA = 2'd2;
  localparam logic [1:0] MODE_PASS  = 2'd3;

  // Whole matrix as held in the register bank.
  typedef struct packed {
    logic [CFG_W-1:0] red_weights;
    logic [CFG_W-1:0] green_weights;
    logic [CFG_W-1:0] blue_weights;
    logic [CFG_W-1:0] alpha_weights;
    logic [CFG_W-1:0] offset_terms;
  } acm_cfg_t;

  // Coefficients feeding one output channel.
  typedef struct packed {
    coef_t wr;
    coef_t wg;
    coef_t wb;
    coef_t wa;
    coef_t off;
  } acm_coef_t;

  // Pick lane c of a register as a signed coefficient.
  function automatic coef_t lane_of(input logic [CFG_W-1:0] word, input logic [1:0] c);
    lane_of = coef_t'(word[COEF_W*c +: COEF_W]);
  endfunction

endpackage

// ===== design/acm_cfg_regs.sv =====
// Configuration register bank holding the colour matrix coefficients.
module acm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  acm_pkg::cfg_idx_t                cfg_index,
  input  logic [acm_pkg::CFG_W-1:0]        cfg_data,
  output acm_pkg::acm_cfg_t                cfg
);
  import acm_pkg::*;

  // Write decode; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_weights   <= RST_RED_WEIGHTS;
      cfg.green_weights <= RST_GREEN_WEIGHTS;
      cfg.blue_weights  <= RST_BLUE_WEIGHTS;
      cfg.alpha_weights <= RST_ALPHA_WEIGHTS;
      cfg.offset_terms  <= RST_OFFSET_TERMS;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_RED_WEIGHTS:   cfg.red_weights   <= cfg_data;
        REG_GREEN_WEIGHTS: cfg.green_weights <= cfg_data;
        REG_BLUE_WEIGHTS:  cfg.blue_weights  <= cfg_data;
        REG_ALPHA_WEIGHTS: cfg.alpha_weights <= cfg_data;
        REG_OFFSET_TERMS:  cfg.offset_terms  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/acm_channel.sv =====
// One output channel: five-term dot product, round half up and clamp to 0..255.
module acm_channel #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [7:0]         alpha,
  input  acm_pkg::acm_coef_t coef,
  output logic [7:0]         result
);
  import acm_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [24:0]      p_red, p_green, p_blue, p_alpha, p_off;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] biased;
  logic [ACC_W-1:0]        shifted;

  // Unsigned pixel values widened to signed before the multiply.
  assign p_red   = 25'($signed({1'b0, red}))   * 25'(coef.wr);
  assign p_green = 25'($signed({1'b0, green})) * 25'(coef.wg);
  assign p_blue  = 25'($signed({1'b0, blue}))  * 25'(coef.wb);
  assign p_alpha = 25'($signed({1'b0, alpha})) * 25'(coef.wa);
  assign p_off   = 25'(9'sd255)                * 25'(coef.off);

  // Exact sum of the five terms.
  assign acc = ACC_W'(p_red) + ACC_W'(p_green) + ACC_W'(p_blue)
             + ACC_W'(p_alpha) + ACC_W'(p_off);

  // Round to nearest with halves going up, then drop the fraction.
  assign biased  = acc + HALF;
  assign shifted = ACC_W'(unsigned'(biased) >> COEF_FRAC_BITS);

  // Negative sums clamp to zero, large ones to full scale.
  always_comb begin
    if (biased[ACC_W-1]) begin
      result = 8'd0;
    end else if (|shifted[ACC_W-1:8]) begin
      result = 8'd255;
    end else begin
      result = shifted[7:0];
    end
  end

endmodule

// ===== design/argb_color_matrix_pixel_top.sv =====
// Top level of the ARGB colour matrix block: input register, channel units, result register.
//
// Takes one ARGB pixel per clock and returns one transformed pixel per clock while
// the output is not stalled. An accepted word is loaded into the input register
// and moves on into the result register whenever that register is free, to be
// offered at the output from there. On its way it passes through four
// parallel channel units (five small multipliers and an adder each) that sit
// between the input register and the result register. A stalled result holds
// while the input register still takes one further word. Coefficients are
// signed with COEF_FRAC_BITS fraction bits, four 16-bit lanes per register,
// lane c feeding output red, green, blue, alpha in that order; reset loads the
// identity matrix. Registers are to be written only while the block is idle.
module argb_color_matrix_pixel_top #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write port
  input  logic                        cfg_write_en,
  input  acm_pkg::cfg_idx_t           cfg_index,
  input  logic [acm_pkg::CFG_W-1:0]   cfg_data,
  // Pixel input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic [7:0]                  in_alpha,
  // Pixel output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_alpha
);
  import acm_pkg::*;

  `include "argb_color_matrix_pixel_top_assert.svh"

  acm_cfg_t   cfg;
  acm_coef_t  coef [4];

  logic       s1_valid;
  logic [1:0] s1_mode;
  logic [7:0] s1_red, s1_green, s1_blue, s1_alpha;
  logic       s1_advance;
  logic       in_accept;

  logic [7:0] op_red, op_green, op_blue, op_alpha;
  logic [7:0] res [4];
  logic [7:0] red_next, green_next, blue_next, alpha_next;

  // Coefficient register bank.
  acm_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  // Handshake: the input register moves on whenever the result register is free.
  assign s1_advance = s1_valid && !(out_valid && out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode  <= req_type;
      s1_red   <= in_red;
      s1_green <= in_green;
      s1_blue  <= in_blue;
      s1_alpha <= in_alpha;
    end
  end

  // Operand selection: RGB mode takes alpha as full scale, alpha mode drops RGB.
  assign op_alpha = (s1_mode == MODE_RGB)   ? 8'd255 : s1_alpha;
  assign op_red   = (s1_mode == MODE_ALPHA) ? 8'd0   : s1_red;
  assign op_green = (s1_mode == MODE_ALPHA) ? 8'd0   : s1_green;
  assign op_blue  = (s1_mode == MODE_ALPHA) ? 8'd0   : s1_blue;

  // Four channel units, one per output lane.
  for (genvar c = 0; c < 4; c++) begin : g_chan
    assign coef[c].wr  = lane_of(cfg.red_weights,   2'(c));
    assign coef[c].wg  = lane_of(cfg.green_weights, 2'(c));
    assign coef[c].wb  = lane_of(cfg.blue_weights,  2'(c));
    assign coef[c].wa  = lane_of(cfg.alpha_weights, 2'(c));
    assign coef[c].off = lane_of(cfg.offset_terms,  2'(c));

    acm_channel #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_chan (
      .red    (op_red),
      .green  (op_green),
      .blue   (op_blue),
      .alpha  (op_alpha),
      .coef   (coef[c]),
      .result (res[c])
    );
  end

  // Choose transformed or passed-through values per request type.
  always_comb begin
    red_next   = s1_red;
    green_next = s1_green;
    blue_next  = s1_blue;
    alpha_next = s1_alpha;
    case (s1_mode)
      MODE_FULL: begin
        red_next   = res[0];
        green_next = res[1];
        blue_next  = res[2];
        alpha_next = res[3];
      end
      MODE_RGB: begin
        red_next   = res[0];
        green_next = res[1];
        blue_next  = res[2];
      end
      MODE_ALPHA: begin
        alpha_next = res[3];
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_red   <= red_next;
      out_green <= green_next;
      out_blue  <= blue_next;
      out_alpha <= alpha_next;
    end
  end

  // The input side only stalls when a finished word is held at the output.
  `ACM_ASSERT_IMPL(a_stall_needs_full_out, clk, rst, in_stall, out_valid && out_stall)
  // An accepted word is always held in the input register next cycle.
  `ACM_ASSERT_NEXT(a_accept_fills_s1, clk, rst, in_accept, s1_valid)
  // A word leaving the input register always reaches the result register.
  `ACM_ASSERT_NEXT(a_advance_fills_out, clk, rst, s1_advance, out_valid)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the ARGB colour matrix block, with driver, monitor and predictor.
`timescale 1ns / 100ps

module testbench;
  import acm_pkg::*;

  localparam int FRAC_BITS = 12;

  // One pixel request as offered on the input side.
  typedef struct {
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_req_t;

  // One returned pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write_en = 1'b0;
  cfg_idx_t         cfg_index = REG_RED_WEIGHTS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       req_type = MODE_FULL;
  logic [7:0]       in_red = 8'd0;
  logic [7:0]       in_green = 8'd0;
  logic [7:0]       in_blue = 8'd0;
  logic [7:0]       in_alpha = 8'd0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic [7:0]       out_alpha;

  // Matrix as the block should hold it, indexed by register number.
  logic [CFG_W-1:0] coef_bank [0:4];

  pixel_req_t pending_px [$];
  pixel_t     predicted_px [$];

  int idle_pct = 20;
  int stall_pct = 20;
  int error_count = 0;
  int sent_count = 0;
  int returned_count = 0;
  int settings_count = 0;
  int mode_seen [4] = '{0, 0, 0, 0};

  argb_color_matrix_pixel_top #(.COEF_FRAC_BITS(FRAC_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_alpha     (in_alpha),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Signed coefficient held in lane c of a register.
  function automatic longint lane_coef(logic [CFG_W-1:0] word, int c);
    coef_t cf;
    cf = word[COEF_W*c +: COEF_W];
    return longint'(cf);
  endfunction

  // Round half up, then clamp to the 8-bit range.
  function automatic logic [7:0] round_sat(longint acc);
    longint h;
    h = acc + (longint'(1) << (FRAC_BITS - 1));
    if (h < 0) return 8'd0;
    h = h >>> FRAC_BITS;
    if (h > 255) return 8'd255;
    return h[7:0];
  endfunction

  // One row of the matrix: four weighted channels plus the scaled offset.
  function automatic logic [7:0] mix_channel(int c, longint r, longint g, longint b,
                                             longint a);
    return round_sat(r * lane_coef(coef_bank[REG_RED_WEIGHTS], c)
                     + g * lane_coef(coef_bank[REG_GREEN_WEIGHTS], c)
                     + b * lane_coef(coef_bank[REG_BLUE_WEIGHTS], c)
                     + a * lane_coef(coef_bank[REG_ALPHA_WEIGHTS], c)
                     + 255 * lane_coef(coef_bank[REG_OFFSET_TERMS], c));
  endfunction

  // Expected output pixel for one request under the current matrix.
  function automatic pixel_t matrix_pixel(pixel_req_t q);
    pixel_t p;
    longint r, g, b, a;
    r = q.red;
    g = q.green;
    b = q.blue;
    a = q.alpha;
    p.red = q.red;
    p.green = q.green;
    p.blue = q.blue;
    p.alpha = q.alpha;
    case (q.mode)
      MODE_FULL: begin
        p.red = mix_channel(0, r, g, b, a);
        p.green = mix_channel(1, r, g, b, a);
        p.blue = mix_channel(2, r, g, b, a);
        p.alpha = mix_channel(3, r, g, b, a);
      end
      MODE_RGB: begin
        p.red = mix_channel(0, r, g, b, 255);
        p.green = mix_channel(1, r, g, b, 255);
        p.blue = mix_channel(2, r, g, b, 255);
      end
      MODE_ALPHA: begin
        p.alpha = round_sat(a * lane_coef(coef_bank[REG_ALPHA_WEIGHTS], 3)
                            + 255 * lane_coef(coef_bank[REG_OFFSET_TERMS], 3));
      end
      default: ;
    endcase
    return p;
  endfunction

  // Count an error; only the first few are described.
  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("testbench: ERROR at %0t: %s", $realtime, msg);
  endtask

  // Driver: offers queued pixels, predicts each one as it is taken.
  always @(posedge clk) begin
    pixel_req_t cur;
    pixel_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.mode = req_type;
        cur.red = in_red;
        cur.green = in_green;
        cur.blue = in_blue;
        cur.alpha = in_alpha;
        predicted_px.push_back(matrix_pixel(cur));
        mode_seen[req_type]++;
        sent_count++;
      end
      // A word on offer stays put until it is taken.
      if (!in_valid || !in_stall) begin
        if (pending_px.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_px.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt.mode;
          in_red <= nxt.red;
          in_green <= nxt.green;
          in_blue <= nxt.blue;
          in_alpha <= nxt.alpha;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls at random and checks each returned word in order.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.red = out_red;
        got.green = out_green;
        got.blue = out_blue;
        got.alpha = out_alpha;
        returned_count++;
        if (predicted_px.size() == 0) begin
          flag_error($sformatf("word %h returned with no pixel outstanding", got));
        end else begin
          want = predicted_px.pop_front();
          if (got !== want)
            flag_error($sformatf("pixel %0d: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                                 returned_count, want.red, want.green, want.blue,
                                 want.alpha, got.red, got.green, got.blue, got.alpha));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic queue_px(logic [1:0] mode, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                          logic [7:0] a);
    pixel_req_t q;
    q.mode = mode;
    q.red = r;
    q.green = g;
    q.blue = b;
    q.alpha = a;
    pending_px.push_back(q);
  endtask

  // Channel value, biased towards the ends and the middle of the range.
  function automatic logic [7:0] pick_channel();
    logic [7:0] edges [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(99) < 30) return edges[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_random_px(int count);
    int pick;
    logic [1:0] mode;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) mode = MODE_FULL;
      else if (pick < 65) mode = MODE_RGB;
      else if (pick < 90) mode = MODE_ALPHA;
      else mode = MODE_PASS;
      queue_px(mode, pick_channel(), pick_channel(), pick_channel(), pick_channel());
    end
  endtask

  // Coefficient lane: moderate gains most often, some extremes, some anything at all.
  function automatic logic [15:0] random_coef();
    logic signed [15:0] v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      v = 16'($urandom_range(10240));
      v = v - 16'sd5120;
      return v;
    end
    if (pick < 60) begin
      case ($urandom_range(3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'h1000;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] random_reg_word();
    return {random_coef(), random_coef(), random_coef(), random_coef()};
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    coef_bank[idx] = val;
  endtask

  task automatic load_matrix(logic [CFG_W-1:0] wr, logic [CFG_W-1:0] wg,
                             logic [CFG_W-1:0] wb, logic [CFG_W-1:0] wa,
                             logic [CFG_W-1:0] off);
    write_reg(REG_RED_WEIGHTS, wr);
    write_reg(REG_GREEN_WEIGHTS, wg);
    write_reg(REG_BLUE_WEIGHTS, wb);
    write_reg(REG_ALPHA_WEIGHTS, wa);
    write_reg(REG_OFFSET_TERMS, off);
    settings_count++;
  endtask

  // Wait until every queued pixel has gone in and come back, then let the pipe empty.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_px.size() != 0 || in_valid || predicted_px.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    logic [CFG_W-1:0] lanes;
    coef_bank[REG_RED_WEIGHTS] = RST_RED_WEIGHTS;
    coef_bank[REG_GREEN_WEIGHTS] = RST_GREEN_WEIGHTS;
    coef_bank[REG_BLUE_WEIGHTS] = RST_BLUE_WEIGHTS;
    coef_bank[REG_ALPHA_WEIGHTS] = RST_ALPHA_WEIGHTS;
    coef_bank[REG_OFFSET_TERMS] = RST_OFFSET_TERMS;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Identity matrix from reset: every mode and the channel extremes.
    @(negedge clk);
    queue_px(MODE_FULL, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_px(MODE_FULL, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_px(MODE_FULL, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
    queue_px(MODE_RGB, 8'd12, 8'd200, 8'd99, 8'd7);
    queue_px(MODE_ALPHA, 8'd1, 8'd2, 8'd3, 8'd250);
    queue_px(MODE_PASS, 8'd255, 8'd0, 8'd255, 8'd0);
    wait_idle();

    // Red feeds +0.5, -0.5, the largest and the most negative gain, so halves
    // round up, negative sums clamp to zero and large sums saturate. A small
    // alpha gain on red shows the 255 used for alpha in the RGB mode, and a
    // -1.0 alpha offset pulls the alpha channel below zero.
    load_matrix(64'h8000_7FFF_F800_0800, 64'h0, 64'h0, 64'h1000_0000_0000_0010,
                64'hF000_0000_0000_0000);
    @(negedge clk);
    queue_px(MODE_FULL, 8'd1, 8'd0, 8'd0, 8'd255);
    queue_px(MODE_FULL, 8'd3, 8'd0, 8'd0, 8'd0);
    queue_px(MODE_FULL, 8'd255, 8'd9, 8'd9, 8'd255);
    queue_px(MODE_RGB, 8'd0, 8'd0, 8'd0, 8'd9);
    queue_px(MODE_RGB, 8'd5, 8'd255, 8'd255, 8'd200);
    queue_px(MODE_ALPHA, 8'd77, 8'd88, 8'd99, 8'd255);
    queue_px(MODE_ALPHA, 8'd1, 8'd2, 8'd3, 8'd0);
    queue_px(MODE_PASS, 8'd0, 8'd255, 8'd0, 8'd255);
    wait_idle();

    // Random pixels under a sequence of matrices, extremes first and the identity matrix last.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: lanes = 64'hFFFF_FFFF_FFFF_FFFF;
        1: lanes = 64'h7FFF_7FFF_7FFF_7FFF;
        2: lanes = 64'h8000_8000_8000_8000;
        default: lanes = '0;
      endcase
      if (ph < 3)
        load_matrix(lanes, lanes, lanes, lanes, lanes);
      else if (ph == 9)
        load_matrix(RST_RED_WEIGHTS, RST_GREEN_WEIGHTS, RST_BLUE_WEIGHTS,
                    RST_ALPHA_WEIGHTS, RST_OFFSET_TERMS);
      else
        load_matrix(random_reg_word(), random_reg_word(), random_reg_word(),
                    random_reg_word(), random_reg_word());
      // One phase runs flat out on both sides.
      idle_pct = (ph == 5) ? 0 : 20;
      stall_pct = (ph == 5) ? 0 : 20;
      @(negedge clk);
      if (ph == 4) begin
        // Hold the input back until the pipe has emptied, mid-phase.
        queue_random_px(47);
        wait_idle();
        @(negedge clk);
        queue_random_px(48);
      end else begin
        queue_random_px(95);
      end
      wait_idle();
    end

    idle_pct = 20;
    stall_pct = 20;
    wait_idle();
    repeat (8) @(posedge clk);
    if (predicted_px.size() != 0)
      flag_error($sformatf("%0d pixels never returned", predicted_px.size()));

    $display("testbench: %0d pixels in (%0d full, %0d rgb, %0d alpha, %0d pass), %0d out",
             sent_count, mode_seen[MODE_FULL], mode_seen[MODE_RGB],
             mode_seen[MODE_ALPHA], mode_seen[MODE_PASS], returned_count);
    $display("testbench: %0d matrix settings loaded, %0d errors", settings_count,
             error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("testbench: timed out");
    $display("testbench: done, errors");
    $finish;
  end

endmodule
